// File: rtl/llsp_pkg.sv
package llsp_pkg;

  localparam int NUM_SERVERS_DEF = 8;
  localparam int RESULT_LIMIT    = 8;
  localparam int LOAD_W          = 16;
  localparam int IDX_W           = 3;
  localparam int CNT_W           = 4;
  localparam int CMD_W           = 2;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LOAD_W-1:0] UNAVAIL_LOAD = 16'hFFFF;
  localparam logic [CNT_W-1:0]  COUNT_RESET  = 4'd8;

  localparam logic [CMD_W-1:0] CMD_REPORT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PICK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  server_index;
    logic [LOAD_W-1:0] load_value;
  } in_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]  server_index_res;
    logic [LOAD_W-1:0] load_value_res;
    logic              available;
    logic              last;
  } out_res_t;

  // classified request held in the queue
  typedef struct packed {
    logic [CMD_W-1:0]  kind;
    logic [IDX_W-1:0]  idx;
    logic [LOAD_W-1:0] load;
  } op_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: rtl/llsp_front.sv
module llsp_front #(
  parameter int NUM_SERVERS = llsp_pkg::NUM_SERVERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [llsp_pkg::CNT_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  llsp_pkg::in_req_t             in_data,
  input  llsp_pkg::q_stat_t             q_stat,
  output logic                          q_push,
  output llsp_pkg::op_t                 q_op,
  output logic [llsp_pkg::CNT_W-1:0]    active_n
);

  localparam int DEPTH = (NUM_SERVERS < llsp_pkg::RESULT_LIMIT) ?
                         NUM_SERVERS : llsp_pkg::RESULT_LIMIT;
  localparam logic [llsp_pkg::CNT_W-1:0] DEPTH_C = llsp_pkg::CNT_W'(DEPTH);

  logic [llsp_pkg::CNT_W-1:0] server_count_r;
  logic                       accept;
  logic                       keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      server_count_r <= llsp_pkg::COUNT_RESET;
    end else if (cfg_wr_en) begin
      server_count_r <= cfg_wr_data;
    end
  end

  // zero counts as one, larger values saturate at the table depth
  always_comb begin
    if (server_count_r == '0) begin
      active_n = llsp_pkg::CNT_W'(1);
    end else if (server_count_r > DEPTH_C) begin
      active_n = DEPTH_C;
    end else begin
      active_n = server_count_r;
    end
  end

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  // reports out of range and unused codes are dropped here
  always_comb begin
    case (in_data.cmd)
      llsp_pkg::CMD_REPORT: keep = ({1'b0, in_data.server_index} < active_n);
      llsp_pkg::CMD_PICK:   keep = 1'b1;
      llsp_pkg::CMD_DUMP:   keep = 1'b1;
      default:              keep = 1'b0;
    endcase
  end

  assign q_push    = accept && keep;
  assign q_op.kind = in_data.cmd;
  assign q_op.idx  = in_data.server_index;
  assign q_op.load = in_data.load_value;

endmodule

// File: rtl/llsp_queue.sv
module llsp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  llsp_pkg::op_t     push_op,
  input  logic              pop,
  output llsp_pkg::op_t     pop_op,
  output llsp_pkg::q_stat_t stat
);

  localparam logic [llsp_pkg::QCNT_W-1:0] FULL_C =
    llsp_pkg::QCNT_W'(llsp_pkg::QUEUE_DEPTH);

  llsp_pkg::op_t                entry_r [llsp_pkg::QUEUE_DEPTH];
  logic [llsp_pkg::QPTR_W-1:0]  wr_ptr_r;
  logic [llsp_pkg::QPTR_W-1:0]  rd_ptr_r;
  logic [llsp_pkg::QCNT_W-1:0]  cnt_r;
  logic [llsp_pkg::QCNT_W-1:0]  cnt_nxt;
  logic                         do_push;
  logic                         do_pop;

  assign stat.full  = (cnt_r == FULL_C);
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_op     = entry_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// File: rtl/llsp_back.sv
module llsp_back #(
  parameter int NUM_SERVERS = llsp_pkg::NUM_SERVERS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [llsp_pkg::CNT_W-1:0] active_n,
  input  llsp_pkg::q_stat_t          q_stat,
  input  llsp_pkg::op_t              q_op,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output llsp_pkg::out_res_t         out_data
);

  localparam int DEPTH  = (NUM_SERVERS < llsp_pkg::RESULT_LIMIT) ?
                          NUM_SERVERS : llsp_pkg::RESULT_LIMIT;
  localparam int TBL_IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_SCAN    = 4'b0010,
    ST_RESOLVE = 4'b0100,
    ST_DUMP    = 4'b1000
  } state_t;

  state_t                           state_r, state_nxt;
  logic [llsp_pkg::LOAD_W-1:0]      tbl_r [DEPTH];
  logic [llsp_pkg::CNT_W-1:0]       ptr_r, ptr_nxt;
  logic [llsp_pkg::IDX_W-1:0]       best_r, best_nxt;
  logic [llsp_pkg::LOAD_W-1:0]      best_load_r, best_load_nxt;
  logic                             out_valid_r, out_valid_nxt;
  llsp_pkg::out_res_t               out_data_r, out_data_nxt;
  logic [llsp_pkg::LOAD_W-1:0]      rd_data;
  logic                             out_free;
  logic                             tbl_we;
  logic [TBL_IW-1:0]                tbl_wa;
  logic [llsp_pkg::LOAD_W-1:0]      tbl_wd;
  logic                             best_avail;
  logic                             dump_last;

  assign rd_data    = tbl_r[ptr_r[TBL_IW-1:0]];
  assign out_free   = !out_valid_r || !out_stall;
  assign best_avail = (best_load_r != llsp_pkg::UNAVAIL_LOAD);
  assign dump_last  = ((ptr_r + 1'b1) == active_n);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    best_nxt      = best_r;
    best_load_nxt = best_load_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    tbl_we        = 1'b0;
    tbl_wa        = q_op.idx[TBL_IW-1:0];
    tbl_wd        = q_op.load;
    case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          q_pop = 1'b1;
          case (q_op.kind)
            llsp_pkg::CMD_REPORT: begin
              tbl_we = 1'b1;
            end
            llsp_pkg::CMD_PICK: begin
              best_nxt      = '0;
              best_load_nxt = tbl_r[0];
              ptr_nxt       = llsp_pkg::CNT_W'(1);
              state_nxt     = ST_SCAN;
            end
            llsp_pkg::CMD_DUMP: begin
              ptr_nxt   = '0;
              state_nxt = ST_DUMP;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // one entry per cycle, strict compare keeps the lowest index on ties
        if (ptr_r < active_n) begin
          if (rd_data < best_load_r) begin
            best_nxt      = ptr_r[llsp_pkg::IDX_W-1:0];
            best_load_nxt = rd_data;
          end
          ptr_nxt = ptr_r + 1'b1;
        end else begin
          state_nxt = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (out_free) begin
          tbl_wa = best_r[TBL_IW-1:0];
          tbl_wd = best_load_r + 1'b1;
          tbl_we = best_avail;
          out_valid_nxt                 = 1'b1;
          out_data_nxt.server_index_res = best_r;
          out_data_nxt.load_value_res   = best_avail ? tbl_wd : best_load_r;
          out_data_nxt.available        = best_avail;
          out_data_nxt.last             = 1'b1;
          state_nxt                     = ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.server_index_res = ptr_r[llsp_pkg::IDX_W-1:0];
          out_data_nxt.load_value_res   = rd_data;
          out_data_nxt.available        = (rd_data != llsp_pkg::UNAVAIL_LOAD);
          out_data_nxt.last             = dump_last;
          ptr_nxt                       = ptr_r + 1'b1;
          if (dump_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ptr_r       <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        tbl_r[i] <= llsp_pkg::UNAVAIL_LOAD;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ptr_r       <= ptr_nxt;
      if (tbl_we) begin
        tbl_r[tbl_wa] <= tbl_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    best_r      <= best_nxt;
    best_load_r <= best_load_nxt;
    out_data_r  <= out_data_nxt;
  end

  a_scan_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (ptr_r <= active_n))
    else $error("scan pointer ran past the active count");

  a_best_behind_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> ({1'b0, best_r} < ptr_r))
    else $error("best candidate not behind scan pointer");

  a_dump_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP && out_free && dump_last) |=>
      (state_r == ST_IDLE && out_valid_r && out_data_r.last))
    else $error("dump did not end with a last result");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE && !q_stat.empty))
    else $error("queue popped outside idle");

endmodule

// File: rtl/least_loaded_server_picker_unit.sv
// least-loaded server picker: a table of one 16-bit load per server
// request channel: in_valid / in_stall / in_data (cmd, server_index, load_value)
//   report writes a server's load, pick returns the least loaded server and
//   bumps its load, dump streams every in-use entry with last on the final one
// result channel: out_valid / out_stall / out_data, one registered result slot
// config: cfg_wr_en / cfg_wr_data set server_count, write only while idle
// a front end takes requests into a two-entry queue; the back end owns the
// table and works one request at a time
// report: written into the table by the back end, no result
// pick: a scan compares one table entry per cycle up to the active count,
//   then the resolve state registers the result once the slot is free
// dump: after idle takes the command, one result per cycle while the slot is free
// reset: every load reads 0xFFFF (unavailable), server_count is 8, queue empty
// a stalled result holds the slot; the back end waits, the queue fills and
// then in_stall rises
module least_loaded_server_picker_unit #(
  parameter int NUM_SERVERS = llsp_pkg::NUM_SERVERS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [llsp_pkg::CNT_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  llsp_pkg::in_req_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output llsp_pkg::out_res_t         out_data
);

  llsp_pkg::q_stat_t          q_stat;
  logic                       q_push;
  logic                       q_pop;
  llsp_pkg::op_t              push_op;
  llsp_pkg::op_t              pop_op;
  logic [llsp_pkg::CNT_W-1:0] active_n;

  llsp_front #(
    .NUM_SERVERS (NUM_SERVERS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_op        (push_op),
    .active_n    (active_n)
  );

  llsp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .pop     (q_pop),
    .pop_op  (pop_op),
    .stat    (q_stat)
  );

  llsp_back #(
    .NUM_SERVERS (NUM_SERVERS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .active_n  (active_n),
    .q_stat    (q_stat),
    .q_op      (pop_op),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
